// ===== hdl/sfpq_pkg.sv =====
package sfpq_pkg;

  // Store geometry.
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  // Span doubling steps of the prefix scan that finds the insert point.
  localparam int unsigned Levels     = IdxW;

  // Stream widths: record fields packed from bit 0 up, padded to whole bytes.
  localparam int unsigned RecW       = 29;
  localparam int unsigned InDataW    = ((RecW + 7) / 8) * 8;
  localparam int unsigned OutDataW   = ((RecW + CntW + 7) / 8) * 8;

  typedef logic [2:0] stage_t;

  localparam stage_t StageMin = 3'd1;
  localparam stage_t StageTop = 3'd5;

  // Request codes carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  // Result codes carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_STAGE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One stored record, record_id in the lowest bits.
  typedef struct packed {
    stage_t      stage;
    logic        fourth_stage;
    logic        comorbidity;
    logic        healthcare;
    logic [6:0]  age;
    logic [15:0] record_id;
  } rec_t;

  // Per-cell move command for one update cycle.
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

// ===== hdl/stable_five_level_priority_queue.sv =====
// Stable five-level priority queue.
//
// Requests enter on the s_axis channel: tuser holds the request code
// (insert by stage, append at tail, remove head) and tdata holds the record.
// Every request gives exactly one result on the m_axis channel: tuser holds
// the status and tdata the removed record (zero when nothing is removed)
// followed by the record count after the request.
//
// The records live in a row of cells, head in cell 0. Each cell compares its
// stage with the incoming one; a prefix scan over those flags picks the
// insert point, and every cell then holds, loads, or takes its neighbor's
// record in the same update.
// A request accepted into the request register executes once the output register
// is free; the cell update and the result register load happen together.
// Throughput: one request per cycle while the result side takes a transaction
// every cycle, as a new request is accepted while the held one executes.
// When the receiver stalls, the result is held and at most one further
// request is taken and kept waiting until the output register frees.
// Reset empties the queue at once (count zero); cell contents are not cleared.
module stable_five_level_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Bits from 0: record_id[15:0], age[22:16], healthcare_flag[23],
  // comorbidity_flag[24], fourth_stage_flag[25], stage[28:26], zero pad.
  input  logic [sfpq_pkg::InDataW-1:0]  s_axis_tdata,
  // Bits from 0: req_type[1:0].
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Bits from 0: out_record_id[15:0], out_age[22:16], out_healthcare[23],
  // out_comorbidity[24], out_fourth_stage[25], out_stage[28:26],
  // occupancy[35:29], zero pad.
  output logic [sfpq_pkg::OutDataW-1:0] m_axis_tdata,
  // Bits from 0: status[1:0].
  output logic [1:0]                    m_axis_tuser
);
  import sfpq_pkg::*;

  logic            busy_q, busy_d;
  logic [1:0]      req_q;
  rec_t            new_q;
  logic [CntW-1:0] count_q, count_d;
  logic            m_valid_q, m_valid_d;
  rec_t            out_rec_q;
  status_e         out_status_q;
  logic [CntW-1:0] out_count_q;

  logic            accept;
  logic            fire;
  logic            is_ins, is_app, is_rem;
  logic            bad_stage, full, write, to_tail, rem_ok;
  status_e         status;

  rec_t                  cell_rec [QueueDepth];
  logic [QueueDepth-1:0] gt, mark, first, after;

  // Handshake: a held request executes when the output register is free.
  assign fire          = busy_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Request decode and status.
  assign is_ins    = (req_q == REQ_INSERT);
  assign is_app    = (req_q == REQ_APPEND);
  assign is_rem    = (req_q == REQ_REMOVE);
  assign bad_stage = is_ins && ((new_q.stage < StageMin) || (new_q.stage > StageTop));
  assign full      = (count_q == CntW'(QueueDepth));
  assign write     = (is_ins || is_app) && !bad_stage && !full;
  assign to_tail   = is_app || (new_q.stage == StageTop);
  assign rem_ok    = is_rem && (count_q != '0);

  always_comb begin
    case (req_q)
      REQ_INSERT, REQ_APPEND: begin
        if (bad_stage) begin
          status = ST_BAD_STAGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
        end
      end
      REQ_REMOVE: status = rem_ok ? ST_OK : ST_EMPTY;
      default:    status = ST_OK;
    endcase
  end

  // Row of cells; each one hands its record to a neighbor when the row shifts.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    rec_t      left_rec, right_rec;
    cell_ctl_t ctl;

    if (i == 0) begin : g_head
      assign left_rec = new_q;
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_rec = cell_rec[i];
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    // Insert point: first cell ranking after the key, or the tail slot.
    assign mark[i] = (gt[i] && !to_tail) || (count_q == CntW'(i));

    assign ctl.load       = fire && write && first[i];
    assign ctl.take_left  = fire && write && after[i];
    assign ctl.take_right = fire && rem_ok;

    sfpq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .new_i   (new_q),
      .left_i  (left_rec),
      .right_i (right_rec),
      .key_i   (new_q.stage),
      .occ_i   (CntW'(i) < count_q),
      .rec_o   (cell_rec[i]),
      .gt_o    (gt[i])
    );
  end

  sfpq_first u_first (
    .mark_i  (mark),
    .first_o (first),
    .after_o (after)
  );

  // Next values of the control state.
  always_comb begin
    busy_d    = busy_q;
    count_d   = count_q;
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (fire) begin
      busy_d    = 1'b0;
      m_valid_d = 1'b1;
      if (write) begin
        count_d = count_q + 1'b1;
      end else if (rem_ok) begin
        count_d = count_q - 1'b1;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= s_axis_tuser;
      new_q <= rec_t'(s_axis_tdata[RecW-1:0]);
    end
    if (fire) begin
      out_rec_q    <= rem_ok ? cell_rec[0] : '0;
      out_status_q <= status;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(OutDataW - RecW - CntW){1'b0}}, out_count_q, out_rec_q};

  // The count never passes the depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("record count above queue depth");

  // A full result reports a full queue.
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (out_status_q == ST_FULL)) |-> (out_count_q == CntW'(QueueDepth)))
    else $error("full status with a queue that is not full");

  // An empty result carries no record and a zero count.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (out_status_q == ST_EMPTY)) |-> ((out_count_q == '0) && (out_rec_q == '0)))
    else $error("empty status with a record or nonzero count");

  // A successful removal drops the count by one.
  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rem_ok) |=> (count_q == CntW'($past(count_q) - 1'b1)))
    else $error("removal did not decrement the count");

  // A stored record raises the count by one.
  a_write_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && write) |=> (count_q == CntW'($past(count_q) + 1'b1)))
    else $error("insert did not increment the count");

endmodule

// ===== hdl/sfpq_cell.sv =====
module sfpq_cell (
  input  logic                clk_i,
  input  sfpq_pkg::cell_ctl_t ctl_i,
  input  sfpq_pkg::rec_t      new_i,
  input  sfpq_pkg::rec_t      left_i,
  input  sfpq_pkg::rec_t      right_i,
  input  sfpq_pkg::stage_t    key_i,
  input  logic                occ_i,
  output sfpq_pkg::rec_t      rec_o,
  output logic                gt_o
);
  import sfpq_pkg::*;

  rec_t rec_q, rec_d;

  // Load the new record, or take the neighbor's record when the row shifts.
  always_comb begin
    rec_d = rec_q;
    if (ctl_i.load) begin
      rec_d = new_i;
    end else if (ctl_i.take_left) begin
      rec_d = left_i;
    end else if (ctl_i.take_right) begin
      rec_d = right_i;
    end
  end

  // Record storage holds payload only, so it has no reset.
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  // An occupied cell whose stage ranks after the key flags itself.
  assign gt_o  = occ_i && (rec_q.stage > key_i);
  assign rec_o = rec_q;

endmodule

// ===== hdl/sfpq_first.sv =====
module sfpq_first (
  input  logic [sfpq_pkg::QueueDepth-1:0] mark_i,
  output logic [sfpq_pkg::QueueDepth-1:0] first_o,
  output logic [sfpq_pkg::QueueDepth-1:0] after_o
);
  import sfpq_pkg::*;

  logic [QueueDepth-1:0] span;

  // Prefix OR toward the tail, doubling the span each step.
  always_comb begin
    span = mark_i;
    for (int l = 0; l < Levels; l++) begin
      span = span | (span << (1 << l));
    end
  end

  // Cells past the first mark shift toward the tail; the first mark loads.
  assign after_o = span << 1;
  assign first_o = mark_i & ~after_o;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfpq_pkg::*;

  // Request code that the block answers without touching the store.
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted = 50;

  typedef struct {
    logic [1:0] code;
    rec_t       rec;
  } request_t;

  typedef struct {
    status_e        status;
    rec_t           rec;
    logic [CntW-1:0] occupancy;
  } response_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  request_t    req_pending_q[$];
  response_t   exp_resp_q[$];
  rec_t        shadow_recs[$];

  logic        req_fired;
  logic        calm;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_off_left;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned req_cnt;
  int unsigned resp_cnt;
  int unsigned peak_occ;
  int unsigned status_cnt[4];

  stable_five_level_priority_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the shadow store and returns the response it must give.
  function automatic response_t apply_request(logic [1:0] code, rec_t rec);
    response_t   r;
    int unsigned pos;
    r.status = ST_OK;
    r.rec = '0;
    if (code == REQ_INSERT || code == REQ_APPEND) begin
      if (code == REQ_INSERT && (rec.stage < StageMin || rec.stage > StageTop)) begin
        r.status = ST_BAD_STAGE;
      end else if (shadow_recs.size() >= QueueDepth) begin
        r.status = ST_FULL;
      end else if (code == REQ_APPEND || rec.stage == StageTop) begin
        shadow_recs.push_back(rec);
      end else begin
        // Skip the leading run of entries at or below the new stage.
        pos = 0;
        while (pos < shadow_recs.size() && shadow_recs[pos].stage <= rec.stage) pos++;
        shadow_recs.insert(pos, rec);
      end
    end else if (code == REQ_REMOVE) begin
      if (shadow_recs.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.rec = shadow_recs.pop_front();
      end
    end
    r.occupancy = CntW'(shadow_recs.size());
    if (shadow_recs.size() > peak_occ) peak_occ = shadow_recs.size();
    status_cnt[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < MaxPrinted) $display("[cycle %0d] mismatch: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task automatic push_req(logic [1:0] code, logic [15:0] id, logic [6:0] age,
                          logic hc, logic cm, logic fs, stage_t stg);
    request_t item;
    item.code = code;
    item.rec.record_id = id;
    item.rec.age = age;
    item.rec.healthcare = hc;
    item.rec.comorbidity = cm;
    item.rec.fourth_stage = fs;
    item.rec.stage = stg;
    req_pending_q.push_back(item);
  endtask

  // Random request; add_pct sets the share of inserts and appends.
  task automatic push_random(int unsigned add_pct);
    int unsigned roll = $urandom_range(0, 99);
    logic [1:0]  code;
    stage_t      stg;
    if (roll < 3) begin
      code = ReqUnused;
    end else if ($urandom_range(0, 99) < add_pct) begin
      code = ($urandom_range(0, 99) < 62) ? REQ_INSERT : REQ_APPEND;
    end else begin
      code = REQ_REMOVE;
    end
    stg = ($urandom_range(0, 9) == 0) ? stage_t'($urandom_range(0, 7))
                                      : stage_t'($urandom_range(1, 5));
    push_req(code, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), stg);
  endtask

  // Request driver: presents the next pending item after each transaction.
  always @(negedge clk_i) begin : drive_requests
    request_t nxt;
    if (rst_ni && (req_fired || !s_axis_tvalid)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_pending_q.size() > 0) begin
        nxt = req_pending_q.pop_front();
        s_axis_tuser <= nxt.code;
        s_axis_tdata <= {{(InDataW - RecW){1'b0}}, nxt.rec};
        s_axis_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each request transaction and checks each result transaction.
  always @(posedge clk_i) begin : watch_ports
    response_t want;
    rec_t      got_rec;
    if (rst_ni) begin
      cycle_cnt++;
      req_fired = s_axis_tvalid && s_axis_tready;
      if (req_fired) begin
        exp_resp_q.push_back(apply_request(s_axis_tuser, rec_t'(s_axis_tdata[RecW-1:0])));
        req_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        resp_cnt++;
        if (exp_resp_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tdata 0x%0h", m_axis_tdata));
        end else begin
          want = exp_resp_q.pop_front();
          got_rec = rec_t'(m_axis_tdata[RecW-1:0]);
          compare_field("status", 32'(m_axis_tuser), 32'(want.status));
          compare_field("record_id", 32'(got_rec.record_id), 32'(want.rec.record_id));
          compare_field("age", 32'(got_rec.age), 32'(want.rec.age));
          compare_field("healthcare", 32'(got_rec.healthcare), 32'(want.rec.healthcare));
          compare_field("comorbidity", 32'(got_rec.comorbidity),
                        32'(want.rec.comorbidity));
          compare_field("fourth_stage", 32'(got_rec.fourth_stage),
                        32'(want.rec.fourth_stage));
          compare_field("stage", 32'(got_rec.stage), 32'(want.rec.stage));
          compare_field("occupancy", 32'(m_axis_tdata[RecW +: CntW]), 32'(want.occupancy));
        end
      end
      if (cycle_cnt > CycleLimit) begin
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                 exp_resp_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus and run control.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_INSERT;
    m_axis_tready = 1'b0;
    req_fired = 1'b0;
    calm = 1'b0;
    send_gap = 0;
    stall_left = 0;
    hold_off_left = 0;
    cycle_cnt = 0;
    err_cnt = 0;
    req_cnt = 0;
    resp_cnt = 0;
    peak_occ = 0;
    status_cnt = '{default: 0};

    // Directed: empty store, refused stages, appends of odd stages, stable order.
    push_req(REQ_REMOVE, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    push_req(ReqUnused, 16'hffff, 7'd127, 1'b1, 1'b1, 1'b1, 3'd7);
    push_req(REQ_INSERT, 16'h0001, 7'd10, 1'b0, 1'b0, 1'b0, 3'd0);
    push_req(REQ_INSERT, 16'h0002, 7'd20, 1'b1, 1'b0, 1'b1, 3'd6);
    push_req(REQ_INSERT, 16'h0003, 7'd30, 1'b0, 1'b1, 1'b0, 3'd7);
    push_req(REQ_APPEND, 16'hffff, 7'd127, 1'b1, 1'b1, 1'b1, 3'd0);
    push_req(REQ_APPEND, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 3'd7);
    push_req(REQ_INSERT, 16'h1234, 7'd45, 1'b1, 1'b0, 1'b0, 3'd3);
    push_req(REQ_INSERT, 16'h2345, 7'd66, 1'b0, 1'b1, 1'b0, 3'd1);
    push_req(REQ_INSERT, 16'h3456, 7'd99, 1'b0, 1'b0, 1'b1, 3'd5);
    push_req(REQ_INSERT, 16'h4567, 7'd1, 1'b1, 1'b1, 1'b0, 3'd3);
    push_req(REQ_INSERT, 16'h5678, 7'd126, 1'b0, 1'b1, 1'b1, 3'd2);
    push_req(REQ_INSERT, 16'h6789, 7'd64, 1'b1, 1'b0, 1'b1, 3'd4);
    push_req(REQ_INSERT, 16'h789a, 7'd63, 1'b1, 1'b1, 1'b1, 3'd1);
    push_req(ReqUnused, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 3'd0);
    // Nine records are held; drain them all and remove once more from empty.
    repeat (10) push_req(REQ_REMOVE, 16'h0000, 7'd0, 1'b0, 1'b0, 1'b0, 3'd0);

    // Random: fill to full, churn at the top, partial drain; end with a full drain.
    repeat (3) begin
      repeat (80) push_random(100);
      repeat (20) push_random(50);
      repeat (30) push_random(10);
    end
    repeat (70) push_random(0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Long receiver hold-off while requests keep coming, so the input backs up.
    while (req_pending_q.size() > 300) @(posedge clk_i);
    hold_off_left = HoldOffCycles;

    // A stretch with no idling on either side.
    while (req_pending_q.size() > 150) @(posedge clk_i);
    calm = 1'b1;
    while (req_pending_q.size() > 80) @(posedge clk_i);
    calm = 1'b0;

    while (req_pending_q.size() > 0 || s_axis_tvalid || exp_resp_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d requests and %0d results in %0d cycles, peak occupancy %0d of %0d.",
             req_cnt, resp_cnt, cycle_cnt, peak_occ, QueueDepth);
    $display("Status mix: ok %0d, empty %0d, bad stage %0d, full %0d; mismatches %0d.",
             status_cnt[ST_OK], status_cnt[ST_EMPTY], status_cnt[ST_BAD_STAGE],
             status_cnt[ST_FULL], err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sfpq_pkg.sv
hdl/sfpq_cell.sv
hdl/sfpq_first.sv
hdl/stable_five_level_priority_queue.sv
verif/tb_top.sv
